// ----- hdl/mspg_pkg.sv -----
// Shared types, codes and arithmetic helpers for the multiplexed servo pulse generator.
// Depends on nothing; imported by mspg_angle_store and the top level.
package mspg_pkg;

	localparam int unsigned SERVO_SLOTS_DEF = 16;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] CFG_SERVO_COUNT = 2'd0;
	localparam logic [1:0] CFG_FIRST_PIN   = 2'd1;

	localparam logic [15:0] TICK_US     = 16'd10;
	localparam logic [16:0] SAFETY_US   = 17'd100000;
	localparam logic [7:0]  ANGLE_MAX   = 8'd180;
	localparam logic [7:0]  ANGLE_RESET = 8'd90;
	localparam logic [10:0] PULSE_MIN   = 11'd500;
	// 2^17 / 3 rounded up
	localparam logic [15:0] RECIP_3     = 16'd43691;

	typedef struct packed {
		logic       wr;
		logic [3:0] waddr;
		logic [7:0] wdata;
		logic       rd;
		logic [3:0] raddr;
		logic       clear;
		logic [4:0] clear_n;
	} store_req_t;

	function automatic logic [7:0] clamp_angle(input logic [7:0] a);
		return (a > ANGLE_MAX) ? ANGLE_MAX : a;
	endfunction

	// 500 + a*1500/180 = 500 + floor(a*25/3)
	function automatic logic [10:0] pulse_of(input logic [7:0] a);
		logic [12:0] x;
		logic [28:0] p;
		x = 13'(clamp_angle(a)) * 13'd25;
		p = 29'(x) * 29'(RECIP_3);
		return PULSE_MIN + 11'(p[28:17]);
	endfunction

	// 20000 us frame split into n slots
	function automatic logic [14:0] slot_len_of(input logic [4:0] n);
		logic [14:0] r;
		case (n)
			5'd1:    r = 15'd20000;
			5'd2:    r = 15'd10000;
			5'd3:    r = 15'd6666;
			5'd4:    r = 15'd5000;
			5'd5:    r = 15'd4000;
			5'd6:    r = 15'd3333;
			5'd7:    r = 15'd2857;
			5'd8:    r = 15'd2500;
			5'd9:    r = 15'd2222;
			5'd10:   r = 15'd2000;
			5'd11:   r = 15'd1818;
			5'd12:   r = 15'd1666;
			5'd13:   r = 15'd1538;
			5'd14:   r = 15'd1428;
			5'd15:   r = 15'd1333;
			5'd16:   r = 15'd1250;
			default: r = 15'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] eff_count(input logic [4:0] cnt, input logic [3:0] first,
		input logic [4:0] slots);
		logic [4:0] n;
		logic [4:0] room;
		n = cnt;
		room = 5'd16 - 5'(first);
		if (n > slots) n = slots;
		if (n > room) n = room;
		return n;
	endfunction

	function automatic logic [15:0] pin_bit(input logic [3:0] first, input logic [3:0] servo);
		return 16'd1 << 4'(first + servo);
	endfunction

	function automatic logic [15:0] used_mask(input logic [3:0] first, input logic [4:0] n);
		logic [16:0] m;
		m = (17'd1 << n) - 17'd1;
		return 16'(m << first);
	endfunction

endpackage

// ----- hdl/mspg_angle_store.sv -----
// Angle store: synchronous memory with registered read and per-entry valid flags.
// An entry whose flag is clear reads as the reset angle. Depends on mspg_pkg.
module mspg_angle_store #(
	parameter int unsigned DEPTH = mspg_pkg::SERVO_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mspg_pkg::store_req_t req,
	output logic [7:0]           rdata
);
	import mspg_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       mem_rd_q;
	logic             hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (5'(i) < req.clear_n) valid_q[i] <= 1'b0;
			end
		end else if (req.wr) begin
			valid_q[req.waddr[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) mem[req.waddr[AW-1:0]] <= req.wdata;
		if (req.rd) begin
			mem_rd_q <= mem[req.raddr[AW-1:0]];
			hit_q    <= valid_q[req.raddr[AW-1:0]];
		end
	end

	assign rdata = hit_q ? mem_rd_q : ANGLE_RESET;

endmodule

// ----- hdl/multiplexed_servo_pulse_generator_unit.sv -----
// Top level of the multiplexed servo pulse generator: input stage, slot/pulse update, output word.
// Depends on mspg_pkg and mspg_angle_store.
//
//   channel  direction  handshake                fields
//   in       into block in_valid / in_stall      kind, servo_sel, angle
//   out      from block out_valid / out_stall    pin_levels, active_servo, read_angle, timeout_hit
//   cfg      into block cfg_we                   cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; a taken word passes through the
// registered read of the angle store, then the update stage, into the output register.
// Reset is immediate: the store reads 90 through its valid flags, no clearing pass.
// A stalled output holds one word in the output register and one in the update stage.
module multiplexed_servo_pulse_generator_unit #(
	parameter int unsigned SERVO_SLOTS = mspg_pkg::SERVO_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  servo_sel,
	input  logic [7:0]  angle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pin_levels,
	output logic [3:0]  active_servo,
	output logic [7:0]  read_angle,
	output logic        timeout_hit,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	import mspg_pkg::*;

	localparam logic [4:0] SLOTS = 5'(SERVO_SLOTS);

	logic [4:0]  count_q;
	logic [3:0]  first_q;
	logic [4:0]  eff_q;
	logic [14:0] slot_len_q;

	logic [15:0] pins_q, pins_n;
	logic [3:0]  ss_q, ss_n, ss_d, ss_inc;
	logic [15:0] pe_q, pe_n, pe_new;
	logic [15:0] sl_q, sl_n, sl_new;
	logic [10:0] tgt_q, tgt_n;
	logic [16:0] saf_q, saf_n, saf_inc;
	logic        hit_n;
	logic [7:0]  rd_n;
	logic        slot_start;
	logic [15:0] cur_bit;

	logic        s1_valid_q;
	logic [1:0]  kind_s1;
	logic [3:0]  idx_s1;
	logic [7:0]  angle_s1;

	logic        advance, accept, go;
	logic        cfg_hit;
	logic [4:0]  new_count, new_eff;
	logic [3:0]  new_first;

	store_req_t  req;

	logic        out_valid_q;
	logic [15:0] out_pins_q;
	logic [3:0]  out_ss_q;
	logic [7:0]  out_rd_q;
	logic        out_hit_q;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !advance;
	assign accept   = in_valid && !in_stall;
	assign go       = s1_valid_q && advance;

	assign cfg_hit   = cfg_we && (cfg_index == CFG_SERVO_COUNT || cfg_index == CFG_FIRST_PIN);
	assign new_count = (cfg_index == CFG_SERVO_COUNT) ? cfg_data : count_q;
	assign new_first = (cfg_index == CFG_FIRST_PIN) ? cfg_data[3:0] : first_q;
	assign new_eff   = eff_count(new_count, new_first, SLOTS);

	// a tick reads the angle of the slot current once the word ahead has been applied
	assign ss_d = go ? ss_n : ss_q;

	always_comb begin
		req         = '0;
		req.wr      = accept && kind == KIND_WRITE && {1'b0, servo_sel} < eff_q;
		req.waddr   = servo_sel;
		req.wdata   = clamp_angle(angle);
		req.rd      = accept;
		req.raddr   = (kind == KIND_TICK) ? ss_d : servo_sel;
		req.clear   = cfg_hit;
		req.clear_n = new_eff;
	end

	mspg_angle_store #(
		.DEPTH(SERVO_SLOTS)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rdata (angle_s1)
	);

	assign saf_inc    = saf_q + 17'(TICK_US);
	assign slot_start = (sl_q == 16'd0);
	assign pe_new     = slot_start ? TICK_US : 16'(pe_q + TICK_US);
	assign sl_new     = 16'(sl_q + TICK_US);
	assign cur_bit    = pin_bit(first_q, ss_q);
	assign ss_inc     = (5'(ss_q) + 5'd1 == eff_q) ? 4'd0 : 4'(ss_q + 4'd1);

	always_comb begin
		pins_n = pins_q;
		ss_n   = ss_q;
		pe_n   = pe_q;
		sl_n   = sl_q;
		tgt_n  = tgt_q;
		saf_n  = saf_q;
		hit_n  = 1'b0;
		rd_n   = '0;
		case (kind_s1)
			KIND_TICK: begin
				if (eff_q != 5'd0) begin
					if (saf_inc >= SAFETY_US) begin
						pins_n = pins_q & ~used_mask(first_q, eff_q);
						saf_n  = '0;
						sl_n   = '0;
						pe_n   = '0;
						ss_n   = '0;
						hit_n  = 1'b1;
					end else begin
						saf_n = saf_inc;
						// a fresh target is at least 500 us, so no drop on the first tick
						if (slot_start) begin
							pins_n = pins_q | cur_bit;
							tgt_n  = pulse_of(angle_s1);
						end else if (pe_new >= 16'(tgt_q)) begin
							pins_n = pins_q & ~cur_bit;
						end
						pe_n = pe_new;
						sl_n = sl_new;
						if (sl_new >= 16'(slot_len_q)) begin
							sl_n = '0;
							pe_n = '0;
							ss_n = ss_inc;
							if (ss_inc == 4'd0) saf_n = '0;
						end
					end
				end
			end
			KIND_READ: begin
				if ({1'b0, idx_s1} < eff_q) rd_n = angle_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			first_q    <= '0;
			eff_q      <= '0;
			slot_len_q <= '0;
			pins_q     <= '0;
			ss_q       <= '0;
			pe_q       <= '0;
			sl_q       <= '0;
			tgt_q      <= '0;
			saf_q      <= '0;
		end else if (cfg_hit) begin
			count_q    <= new_count;
			first_q    <= new_first;
			eff_q      <= new_eff;
			slot_len_q <= slot_len_of(new_eff);
			pins_q     <= '0;
			ss_q       <= '0;
			pe_q       <= '0;
			sl_q       <= '0;
			tgt_q      <= '0;
			saf_q      <= '0;
		end else if (go) begin
			pins_q <= pins_n;
			ss_q   <= ss_n;
			pe_q   <= pe_n;
			sl_q   <= sl_n;
			tgt_q  <= tgt_n;
			saf_q  <= saf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) s1_valid_q <= 1'b1;
			else if (advance) s1_valid_q <= 1'b0;
			if (go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			idx_s1  <= servo_sel;
		end
		if (go) begin
			out_pins_q <= pins_n;
			out_ss_q   <= ss_n;
			out_rd_q   <= rd_n;
			out_hit_q  <= hit_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign pin_levels   = out_pins_q;
	assign active_servo = out_ss_q;
	assign read_angle   = out_rd_q;
	assign timeout_hit  = out_hit_q;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && out_stall) |=> s1_valid_q)
		else $error("update stage lost a word while output stalled");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eff_q != 5'd0) |-> (5'(ss_q) < eff_q))
		else $error("slot servo beyond servo count");

	a_safety_range: assert property (@(posedge clk) disable iff (!arst_n)
		saf_q < SAFETY_US)
		else $error("safety count passed its limit");

	a_stop_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_hit_q) |-> ((out_pins_q & used_mask(first_q, eff_q)) == 16'd0))
		else $error("safety stop left a servo pin high");

endmodule
